// ===== rtl/nrc_pkg.sv =====
`timescale 1ns / 1ps

package nrc_pkg;

   // Request kinds carried on req_tuser
   typedef enum logic [1:0] {
      REQ_CHECK = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_NONE  = 2'd3
   } nrc_req_type;

   // Fixed field widths on the stream ports
   localparam int TYPE_W      = 2;
   localparam int KEY_W       = 64;
   localparam int NOW_W       = 32;
   localparam int TTL_W       = 32;
   localparam int REQ_DATA_W  = 96;
   localparam int RSP_DATA_W  = 8;

   // Field positions in req_tdata
   localparam int KEY_LSB     = 0;
   localparam int NOW_LSB     = KEY_LSB + KEY_W;

   localparam logic [TTL_W-1:0] TTL_RESET = 32'd60;

   // Controller to datapath
   typedef struct packed {
      logic start;     // take the request fields, rewind the scan
      logic advance;   // step the read address
      logic eval;      // judge the entry whose data is on the read register
      logic exec;      // run add, clear or no-op
      logic load_rsp;  // move the result into the output register
   } nrc_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic hit;       // judged entry is live, unexpired and matches a nonzero key
      logic last;      // judged entry is the final one
   } nrc_status_type;

endpackage

// ===== rtl/nrc_ctrl.sv =====
`timescale 1ns / 1ps

module nrc_ctrl
   import nrc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  nrc_req_type    req_kind,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   output nrc_cmd_type    cmd,
   input  nrc_status_type status
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_PRIME  = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_EXEC   = 5'b01000,
      ST_FINISH = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_xfer;
   logic      rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               cmd.start = 1'b1;
               state_in  = (req_kind == REQ_CHECK) ? ST_PRIME : ST_EXEC;
            end
         end
         ST_PRIME: begin
            cmd.advance = 1'b1;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.advance = 1'b1;
            cmd.eval    = 1'b1;
            if (status.hit || status.last) begin
               state_in = ST_FINISH;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/nrc_datapath.sv =====
`timescale 1ns / 1ps

module nrc_datapath
   import nrc_pkg::*;
#(
   parameter int ENTRIES   = 64,
   parameter int KEY_BITS  = 64,
   parameter int TIME_BITS = 32
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic [TYPE_W-1:0]     req_tuser,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  csr_write,
   input  logic [TTL_W-1:0]      csr_data,
   input  nrc_cmd_type           cmd,
   output nrc_status_type        status,
   output logic                  rsp_found
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int CMP_W = (TIME_BITS > TTL_W) ? TIME_BITS : TTL_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   logic [KEY_BITS-1:0]  key_mem   [ENTRIES];
   logic [TIME_BITS-1:0] stamp_mem [ENTRIES];

   nrc_req_type          type_ff, type_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [TIME_BITS-1:0] now_ff, now_in;
   logic [TTL_W-1:0]     ttl_ff, ttl_in;
   logic [IDX_W-1:0]     rd_addr_ff, rd_addr_in;
   logic [IDX_W-1:0]     eval_addr_ff;
   logic [KEY_BITS-1:0]  rd_key_ff;
   logic [TIME_BITS-1:0] rd_stamp_ff;
   logic [IDX_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic                 result_ff, result_in;
   logic                 found_ff, found_in;

   logic                 mem_we;
   logic                 live;
   logic [TIME_BITS-1:0] age;
   logic                 expired;
   logic                 hit;

   // Entry judgment on the registered read data
   assign live    = valid_ff[eval_addr_ff];
   assign age     = now_ff - rd_stamp_ff;
   assign expired = live && !age[TIME_BITS-1] && (CMP_W'(age) > CMP_W'(ttl_ff));
   assign hit     = live && !expired && (key_ff != '0) && (rd_key_ff == key_ff);

   assign status.hit  = hit;
   assign status.last = (eval_addr_ff == LAST_IDX);
   assign rsp_found   = found_ff;

   assign mem_we = cmd.exec && (type_ff == REQ_ADD);

   always_comb begin
      type_in    = type_ff;
      key_in     = key_ff;
      now_in     = now_ff;
      rd_addr_in = rd_addr_ff;
      result_in  = result_ff;
      found_in   = found_ff;
      wr_ptr_in  = wr_ptr_ff;
      valid_in   = valid_ff;
      ttl_in     = csr_write ? csr_data : ttl_ff;

      if (cmd.start) begin
         type_in    = nrc_req_type'(req_tuser);
         key_in     = KEY_BITS'(req_tdata[KEY_LSB +: KEY_W]);
         now_in     = TIME_BITS'(req_tdata[NOW_LSB +: NOW_W]);
         rd_addr_in = '0;
         result_in  = 1'b0;
      end else if (cmd.advance) begin
         rd_addr_in = (rd_addr_ff == LAST_IDX) ? '0 : rd_addr_ff + 1'b1;
      end

      if (cmd.eval) begin
         if (expired) begin
            valid_in[eval_addr_ff] = 1'b0;
         end
         if (hit) begin
            result_in = 1'b1;
         end
      end

      if (cmd.exec) begin
         unique case (type_ff)
            REQ_ADD: begin
               valid_in[wr_ptr_ff] = 1'b1;
               wr_ptr_in = (wr_ptr_ff == LAST_IDX) ? '0 : wr_ptr_ff + 1'b1;
            end
            REQ_CLEAR: begin
               valid_in  = '0;
               wr_ptr_in = '0;
            end
            REQ_CHECK, REQ_NONE: begin
            end
            default: begin
            end
         endcase
      end

      if (cmd.load_rsp) begin
         found_in = result_ff;
      end
   end

   // Key and stamp store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         key_mem[wr_ptr_ff]   <= key_ff;
         stamp_mem[wr_ptr_ff] <= now_ff;
      end
      rd_key_ff    <= key_mem[rd_addr_ff];
      rd_stamp_ff  <= stamp_mem[rd_addr_ff];
      eval_addr_ff <= rd_addr_ff;
   end

   always_ff @(posedge clock) begin
      type_ff    <= type_in;
      key_ff     <= key_in;
      now_ff     <= now_in;
      rd_addr_ff <= rd_addr_in;
      result_ff  <= result_in;
      found_ff   <= found_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ttl_ff    <= TTL_RESET;
         wr_ptr_ff <= '0;
         valid_ff  <= '0;
      end else begin
         ttl_ff    <= ttl_in;
         wr_ptr_ff <= wr_ptr_in;
         valid_ff  <= valid_in;
      end
   end

endmodule

// ===== rtl/nonce_replay_cache.sv =====
`timescale 1ns / 1ps

// Channel  | Direction | Handshake                | Payload
// ---------+-----------+--------------------------+----------------------------------------
// req      | in        | req_tvalid / req_tready  | req_tuser: type; req_tdata: key, time
// rsp      | out       | rsp_tvalid / rsp_tready  | rsp_tdata: replay found
// csr      | in        | csr_valid / csr_ready    | csr_data: ttl
//
// A check primes the key/stamp read port after the transfer, then judges one entry per cycle
// until the first live match or the final entry. Add, clear and the unused kind pass through
// the execute state instead. The single read port of the store sets the scan rate. Reset
// empties the cache, rewinds the write pointer, loads ttl = 60 and drops any pending result.
// A stalled result holds in the output register; the block finishes the next request and
// waits until that register frees.

module nonce_replay_cache
   import nrc_pkg::*;
#(
   parameter int ENTRIES   = 64,
   parameter int KEY_BITS  = 64,
   parameter int TIME_BITS = 32
)(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // req_tuser, lowest bit up: req_type [1:0]
   input  logic [TYPE_W-1:0]     req_tuser,
   // req_tdata, lowest bit up: nonce_key [63:0], now_time [95:64]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata, lowest bit up: replay_found [0], zeros
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // ttl register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [TTL_W-1:0]      csr_data
);

   nrc_cmd_type    cmd;
   nrc_status_type status;
   logic           found;

   // Configuration is taken at any cycle
   assign csr_ready = 1'b1;

   // Pad the single result bit out to a whole byte
   assign rsp_tdata = RSP_DATA_W'(found);

   nrc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (nrc_req_type'(req_tuser)),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // Store, scan logic, ttl and the output data register
   nrc_datapath #(
      .ENTRIES   (ENTRIES),
      .KEY_BITS  (KEY_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_found (found)
   );

endmodule
